>>> hdl/tbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int HISTORY_BITS_DEF  = 8;
    localparam int COUNTER_BITS_DEF  = 2;
    localparam int STACK_DEPTH_DEF   = 8;

    localparam logic [31:0] PC_STEP = 32'd4;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic exec;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_status;

endpackage

`default_nettype wire

>>> hdl/tournament_branch_predictor_unit.sv
// a prediction shows on o_next_pc with o_valid after start is taken and the lookup and exec
// states have run; a new item is taken only once idle again, after the dependent read of the local
// history table and then the local counter table before the evaluate and write state
// reset: synchronous; afterwards busy stays high while a pass clears the history, counter
// and target tables one entry a cycle; the return stack starts empty
// o_valid lasts one cycle and the receiver cannot stall it
`timescale 1ns / 1ps
`default_nettype none

module tournament_branch_predictor_unit
    import tbp_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int HISTORY_BITS  = HISTORY_BITS_DEF,
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_kind,
    input  wire logic [31:0] i_pc,
    input  wire logic        i_is_branch,
    input  wire logic        i_is_conditional,
    input  wire logic        i_taken,
    input  wire logic [31:0] i_target,
    output logic             o_valid,
    output logic [31:0]      o_next_pc
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tbp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    tbp_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HISTORY_BITS  (HISTORY_BITS),
        .COUNTER_BITS  (COUNTER_BITS),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_kind           (i_kind),
        .i_pc             (i_pc),
        .i_is_branch      (i_is_branch),
        .i_is_conditional (i_is_conditional),
        .i_taken          (i_taken),
        .i_target         (i_target),
        .o_valid          (o_valid),
        .o_next_pc        (o_next_pc)
    );

endmodule

`default_nettype wire

>>> hdl/tbp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tbp_ctrl
    import tbp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CLEAR  = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;
    localparam logic [1:0] ST_EXEC   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOOKUP;
                end
            end
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

>>> hdl/tbp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tbp_datapath
    import tbp_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int HISTORY_BITS  = HISTORY_BITS_DEF,
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    input  wire logic        i_kind,
    input  wire logic [31:0] i_pc,
    input  wire logic        i_is_branch,
    input  wire logic        i_is_conditional,
    input  wire logic        i_taken,
    input  wire logic [31:0] i_target,
    output logic             o_valid,
    output logic [31:0]      o_next_pc
);

    localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
    localparam int PHT     = 1 << HISTORY_BITS;
    localparam int CLR_N   = (TABLE_ENTRIES > PHT) ? TABLE_ENTRIES : PHT;
    localparam int CLR_W   = $clog2(CLR_N);
    localparam int TAG_LSB = $clog2(TABLE_ENTRIES + 1) + 1;
    localparam int SP_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam logic [COUNTER_BITS-1:0] CTR_MAX = '1;

    logic [HISTORY_BITS-1:0] lh_mem [TABLE_ENTRIES];
    logic [COUNTER_BITS-1:0] lc_mem [PHT];
    logic [COUNTER_BITS-1:0] gc_mem [PHT];
    logic [COUNTER_BITS-1:0] ch_mem [PHT];
    logic [31:0]             tb_mem [TABLE_ENTRIES];
    logic [31:0]             rs_mem [STACK_DEPTH];

    logic                    r_kind;
    logic [31:0]             r_pc;
    logic                    r_br;
    logic                    r_cond;
    logic                    r_taken;
    logic [31:0]             r_target;
    logic [SLOT_W-1:0]       r_slot;
    logic [HISTORY_BITS-1:0] r_cidx;
    logic [HISTORY_BITS-1:0] r_lh_q;
    logic [COUNTER_BITS-1:0] r_lc_q;
    logic [COUNTER_BITS-1:0] r_gc_q;
    logic [COUNTER_BITS-1:0] r_ch_q;
    logic [31:0]             r_tb_q;
    logic [31:0]             r_rs_q;
    logic [HISTORY_BITS-1:0] r_ghist;
    logic [SP_W-1:0]         r_base;
    logic [CNT_W-1:0]        r_count;
    logic [CLR_W-1:0]        r_clr;
    logic                    r_valid;
    logic [31:0]             r_next_pc;

    logic [SLOT_W-1:0]       w_slot;
    logic [HISTORY_BITS-1:0] w_cidx;
    logic [SUM_W-1:0]        w_top_sum;
    logic [SP_W-1:0]         w_top;
    logic [SUM_W-1:0]        w_push_sum;
    logic [SP_W-1:0]         w_push;
    logic [SP_W-1:0]         w_base_inc;
    logic                    w_full;
    logic                    w_lp;
    logic                    w_gp;
    logic                    w_pred;
    logic                    w_match;
    logic [31:0]             w_next_pc;
    logic                    w_upd_cond;
    logic                    w_push_en;
    logic                    w_pop_en;
    logic [COUNTER_BITS-1:0] w_lc_new;
    logic [COUNTER_BITS-1:0] w_gc_new;
    logic                    w_ch_wr;
    logic [COUNTER_BITS-1:0] w_ch_new;
    logic [HISTORY_BITS:0]   w_lh_shift;
    logic [HISTORY_BITS:0]   w_gh_shift;
    logic                    w_clr_slot;
    logic                    w_clr_pht;

    // index extraction
    assign w_slot = SLOT_W'((i_pc >> 2) & 32'(TABLE_ENTRIES - 1));
    assign w_cidx = i_pc[HISTORY_BITS+1:2];

    // return stack pointers, wrapped with one compare and subtract
    always_comb begin
        w_top_sum  = SUM_W'(r_base) + SUM_W'(r_count) - SUM_W'(1);
        if (w_top_sum >= SUM_W'(STACK_DEPTH)) begin
            w_top_sum = w_top_sum - SUM_W'(STACK_DEPTH);
        end
        w_top      = w_top_sum[SP_W-1:0];
        w_push_sum = SUM_W'(r_base) + SUM_W'(r_count);
        if (w_push_sum >= SUM_W'(STACK_DEPTH)) begin
            w_push_sum = w_push_sum - SUM_W'(STACK_DEPTH);
        end
        w_full     = (r_count == CNT_W'(STACK_DEPTH));
        w_push     = w_full ? r_base : w_push_sum[SP_W-1:0];
        if (SUM_W'(r_base) + SUM_W'(1) >= SUM_W'(STACK_DEPTH)) begin
            w_base_inc = '0;
        end else begin
            w_base_inc = r_base + SP_W'(1);
        end
    end

    // prediction
    assign w_lp    = r_lc_q[COUNTER_BITS-1];
    assign w_gp    = r_gc_q[COUNTER_BITS-1];
    assign w_pred  = r_ch_q[COUNTER_BITS-1] ? w_gp : w_lp;
    assign w_match = (r_pc[31:TAG_LSB] == r_tb_q[31:TAG_LSB]);

    always_comb begin
        w_next_pc = r_pc + PC_STEP;
        if (r_br && r_cond && w_pred && w_match) begin
            w_next_pc = r_tb_q;
        end else if (r_br && !r_cond && (r_count != '0)) begin
            w_next_pc = r_rs_q;
        end
    end

    assign w_upd_cond = i_cmd.exec && r_kind && r_br && r_cond;
    assign w_push_en  = i_cmd.exec && r_kind && r_br && !r_cond;
    assign w_pop_en   = i_cmd.exec && !r_kind && r_br && !r_cond && (r_count != '0);

    // training
    always_comb begin
        if (r_taken) begin
            w_lc_new = (r_lc_q == CTR_MAX) ? r_lc_q : r_lc_q + COUNTER_BITS'(1);
            w_gc_new = (r_gc_q == CTR_MAX) ? r_gc_q : r_gc_q + COUNTER_BITS'(1);
        end else begin
            w_lc_new = (r_lc_q == '0) ? r_lc_q : r_lc_q - COUNTER_BITS'(1);
            w_gc_new = (r_gc_q == '0) ? r_gc_q : r_gc_q - COUNTER_BITS'(1);
        end
        w_ch_wr  = 1'b0;
        w_ch_new = r_ch_q;
        if ((w_lp == r_taken) && (w_gp != r_taken)) begin
            w_ch_wr  = 1'b1;
            w_ch_new = (r_ch_q == '0) ? r_ch_q : r_ch_q - COUNTER_BITS'(1);
        end else if ((w_lp != r_taken) && (w_gp == r_taken)) begin
            w_ch_wr  = 1'b1;
            w_ch_new = (r_ch_q == CTR_MAX) ? r_ch_q : r_ch_q + COUNTER_BITS'(1);
        end
    end

    assign w_lh_shift = {r_lh_q, r_taken};
    assign w_gh_shift = {r_ghist, r_taken};

    assign w_clr_slot = i_cmd.clear && ({1'b0, r_clr} < (CLR_W + 1)'(TABLE_ENTRIES));
    assign w_clr_pht  = i_cmd.clear && ({1'b0, r_clr} < (CLR_W + 1)'(PHT));

    assign o_status.clear_last = (r_clr == CLR_W'(CLR_N - 1));

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_pc     <= i_pc;
            r_br     <= i_is_branch;
            r_cond   <= i_is_conditional;
            r_taken  <= i_taken;
            r_target <= i_target;
            r_slot   <= w_slot;
            r_cidx   <= w_cidx;
        end
    end

    // local history table
    always_ff @(posedge i_clk) begin
        if (w_clr_slot) begin
            lh_mem[r_clr[SLOT_W-1:0]] <= '0;
        end else if (w_upd_cond) begin
            lh_mem[r_slot] <= w_lh_shift[HISTORY_BITS-1:0];
        end
        if (i_cmd.capture) begin
            r_lh_q <= lh_mem[w_slot];
        end
    end

    // local counters, read with the local history just fetched
    always_ff @(posedge i_clk) begin
        if (w_clr_pht) begin
            lc_mem[r_clr[HISTORY_BITS-1:0]] <= '0;
        end else if (w_upd_cond) begin
            lc_mem[r_lh_q] <= w_lc_new;
        end
        if (i_cmd.lookup) begin
            r_lc_q <= lc_mem[r_lh_q];
        end
    end

    // global counters
    always_ff @(posedge i_clk) begin
        if (w_clr_pht) begin
            gc_mem[r_clr[HISTORY_BITS-1:0]] <= '0;
        end else if (w_upd_cond) begin
            gc_mem[r_ghist] <= w_gc_new;
        end
        if (i_cmd.capture) begin
            r_gc_q <= gc_mem[r_ghist];
        end
    end

    // chooser counters
    always_ff @(posedge i_clk) begin
        if (w_clr_pht) begin
            ch_mem[r_clr[HISTORY_BITS-1:0]] <= '0;
        end else if (w_upd_cond && w_ch_wr) begin
            ch_mem[r_cidx] <= w_ch_new;
        end
        if (i_cmd.capture) begin
            r_ch_q <= ch_mem[w_cidx];
        end
    end

    // target buffer
    always_ff @(posedge i_clk) begin
        if (w_clr_slot) begin
            tb_mem[r_clr[SLOT_W-1:0]] <= '0;
        end else if (w_upd_cond && r_taken) begin
            tb_mem[r_slot] <= r_target;
        end
        if (i_cmd.capture) begin
            r_tb_q <= tb_mem[w_slot];
        end
    end

    // return stack storage
    always_ff @(posedge i_clk) begin
        if (w_push_en) begin
            rs_mem[w_push] <= r_target;
        end
        if (i_cmd.capture) begin
            r_rs_q <= rs_mem[w_top];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ghist <= '0;
            r_base  <= '0;
            r_count <= '0;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (w_upd_cond) begin
                r_ghist <= w_gh_shift[HISTORY_BITS-1:0];
            end
            if (w_push_en) begin
                if (w_full) begin
                    r_base <= w_base_inc;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (w_pop_en) begin
                r_count <= r_count - CNT_W'(1);
            end
            r_valid <= i_cmd.exec && !r_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_next_pc <= w_next_pc;
        end
    end

    assign o_valid   = r_valid;
    assign o_next_pc = r_next_pc;

endmodule

`default_nettype wire

>>> hdl/tbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tbp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        i_kind,
    input wire logic        o_valid,
    input wire logic [31:0] o_next_pc
);

    // a predict item gives a result after the lookup and exec states
    a_predict_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_kind |-> ##3 o_valid)
        else $error("predict item produced no result");

    // an update item gives no result
    a_update_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_kind |-> ##3 !o_valid)
        else $error("update item produced a result");

    // accepted item keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting an item");

    // results never on consecutive cycles
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // result only while idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && !$isunknown(o_next_pc))
        else $error("result shown while busy or unknown");

endmodule

bind tournament_branch_predictor_unit tbp_checker u_tbp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_kind    (i_kind),
    .o_valid   (o_valid),
    .o_next_pc (o_next_pc)
);

`default_nettype wire
